// ----- sv/sv39ptw_pkg.sv -----
package sv39ptw_pkg;

	localparam int PPN_BITS_DEF = 44;
	localparam int VA_W         = 39;
	localparam int WORD_W       = 64;
	localparam int ADDR_W       = 56;
	localparam int IDX_W        = 9;
	localparam int PAGE_SHIFT   = 12;
	localparam int PPN_SHIFT    = 10;
	localparam int OFF_L2_W     = 30;
	localparam int OFF_L1_W     = 21;
	localparam int OFF_L0_W     = 12;
	localparam int S_TDATA_W    = 168;   // 39 + 64 + 64 = 167, byte padded
	localparam int M_TDATA_W    = 120;   // 56 + 56 + 1 = 113, byte padded

	// PTE flag bits
	localparam int PTE_V = 0;
	localparam int PTE_R = 1;
	localparam int PTE_W = 2;
	localparam int PTE_X = 3;

	// input op codes
	localparam logic OP_REQ  = 1'b0;
	localparam logic OP_RESP = 1'b1;

	// result kind codes
	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_L2,
		ST_L1,
		ST_L0
	} walk_state_t;

	typedef struct packed {
		logic              op;
		logic [VA_W-1:0]   virt_addr;
		logic [WORD_W-1:0] root_word;
		logic [WORD_W-1:0] read_data;
	} item_t;

	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] read_addr;
		logic [ADDR_W-1:0] xlat_addr;
		logic              fault;
	} result_t;

endpackage

// ----- sv/sv39_page_table_walker_unit.sv -----
// Channel   Dir  tdata (low bit up)                                tuser
// s_*       in   virt_addr[38:0] root_word[102:39] read_data[166:103]  op
// m_*       out  read_addr[55:0] xlat_addr[111:56] fault[112]          kind
//
// One transaction in, at most one out: input register, then the walk
// decision and state update, then the output register.
// Throughput is one transaction per cycle, limited only by m_tready.
// arst_n clears the valid flags and returns the walker to idle.
// A stalled result holds the output register; the input register then holds
// too, unless its transaction produces no result (dropped ones drain freely).
module sv39_page_table_walker_unit #(
	parameter int PPN_BITS = sv39ptw_pkg::PPN_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sv39ptw_pkg::S_TDATA_W-1:0] s_tdata,  // virt_addr, root_word, read_data
	input  logic                              s_tuser,  // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sv39ptw_pkg::M_TDATA_W-1:0] m_tdata,  // read_addr, xlat_addr, fault
	output logic                              m_tuser   // kind
);
	import sv39ptw_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        has_result;
	result_t     result;
	walk_state_t state;
	logic        out_free;
	logic        advance;
	logic        load;

	// s1 moves on when its result can be written, or when it makes none
	assign advance  = valid_s1 && (!has_result || out_free);
	assign load     = advance && has_result;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= s_tuser;
			item_s1.virt_addr <= s_tdata[VA_W-1:0];
			item_s1.root_word <= s_tdata[VA_W +: WORD_W];
			item_s1.read_data <= s_tdata[VA_W+WORD_W +: WORD_W];
		end
	end

	sv39ptw_walk #(
		.PPN_BITS(PPN_BITS)
	) u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.advance   (advance),
		.has_result(has_result),
		.result    (result),
		.state     (state)
	);

	sv39ptw_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.din     (result),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// a read request leaves the walker busy
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load && result.kind == KIND_READ |=> state != ST_IDLE)
		else $error("walker idle after issuing a read request");

	// a final result leaves the walker idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && result.kind == KIND_DONE |=> state == ST_IDLE)
		else $error("walker busy after final result");

	// a held input item does not change
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a stalled transaction");

	// read requests never carry a fault
	a_no_read_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_READ |-> !m_tdata[2*ADDR_W])
		else $error("read request flagged as fault");

endmodule

// ----- sv/sv39ptw_walk.sv -----
module sv39ptw_walk #(
	parameter int PPN_BITS = sv39ptw_pkg::PPN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sv39ptw_pkg::item_t  item,
	input  logic                advance,
	output logic                has_result,
	output sv39ptw_pkg::result_t result,
	output sv39ptw_pkg::walk_state_t state
);
	import sv39ptw_pkg::*;

	walk_state_t       state_q;
	walk_state_t       state_nxt;
	logic [VA_W-1:0]   held_q;
	logic [ADDR_W-1:0] base;
	logic [ADDR_W-1:0] root_addr;
	logic [IDX_W-1:0]  top_idx;
	logic              pte_valid;
	logic              pte_leaf;

	assign state     = state_q;
	assign top_idx   = item.virt_addr[VA_W-1 -: IDX_W];
	assign root_addr = ADDR_W'(item.root_word[PPN_BITS-1:0]) << PAGE_SHIFT;
	assign base      = ADDR_W'(item.read_data[PPN_SHIFT +: PPN_BITS]) << PAGE_SHIFT;
	assign pte_valid = item.read_data[PTE_V];
	assign pte_leaf  = item.read_data[PTE_R] | item.read_data[PTE_W] | item.read_data[PTE_X];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item.op == OP_REQ && top_idx == '0) begin
					state_nxt = ST_L2;
				end
			end
			ST_L2: begin
				if (item.op == OP_RESP) begin
					state_nxt = (pte_valid && !pte_leaf) ? ST_L1 : ST_IDLE;
				end
			end
			ST_L1: begin
				if (item.op == OP_RESP) begin
					state_nxt = (pte_valid && !pte_leaf) ? ST_L0 : ST_IDLE;
				end
			end
			ST_L0: begin
				if (item.op == OP_RESP) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// result
	always_comb begin
		has_result = 1'b0;
		result     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item.op == OP_REQ) begin
					has_result = 1'b1;
					if (top_idx != '0) begin
						result.kind  = KIND_DONE;
						result.fault = 1'b1;
					end else begin
						result.kind      = KIND_READ;
						result.read_addr = root_addr;
					end
				end
			end
			ST_L2, ST_L1: begin
				if (item.op == OP_RESP) begin
					has_result = 1'b1;
					if (!pte_valid) begin
						result.kind  = KIND_DONE;
						result.fault = 1'b1;
					end else if (pte_leaf) begin
						result.kind = KIND_DONE;
						if (state_q == ST_L2) begin
							result.xlat_addr = base | ADDR_W'(held_q[OFF_L2_W-1:0]);
						end else begin
							result.xlat_addr = base | ADDR_W'(held_q[OFF_L1_W-1:0]);
						end
					end else begin
						result.kind = KIND_READ;
						if (state_q == ST_L2) begin
							result.read_addr = base |
								ADDR_W'({held_q[OFF_L2_W-1 -: IDX_W], 3'b000});
						end else begin
							result.read_addr = base |
								ADDR_W'({held_q[OFF_L1_W-1 -: IDX_W], 3'b000});
						end
					end
				end
			end
			ST_L0: begin
				if (item.op == OP_RESP) begin
					has_result = 1'b1;
					result.kind = KIND_DONE;
					if (!pte_valid) begin
						result.fault = 1'b1;
					end else begin
						result.xlat_addr = base | ADDR_W'(held_q[OFF_L0_W-1:0]);
					end
				end
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// latched VA of the walk in progress
	always_ff @(posedge clk) begin
		if (advance && state_q == ST_IDLE && item.op == OP_REQ) begin
			held_q <= item.virt_addr;
		end
	end

endmodule

// ----- sv/sv39ptw_out_reg.sv -----
module sv39ptw_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  sv39ptw_pkg::result_t din,
	output logic                 free,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [sv39ptw_pkg::M_TDATA_W-1:0] m_tdata,
	output logic                 m_tuser
);
	import sv39ptw_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tdata  = M_TDATA_W'({res_q.fault, res_q.xlat_addr, res_q.read_addr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= din;
		end
	end

endmodule

// ----- verif/tb_sv39_page_table_walker_unit.sv -----
`timescale 1ns / 1ps

// Sv39 walker bench: a scripted list of requests and entry responses is
// streamed into the walker, a shadow walker predicts every transaction that
// should come out, and the monitor checks them in order.
module tb_sv39_page_table_walker_unit;
	import sv39ptw_pkg::*;

	localparam int PPN_W       = PPN_BITS_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LIVE_TARGET = 1000;     // random transactions that do real work
	localparam int CALM_TAIL   = 150;      // last stretch of the run has no idling
	localparam int DRAIN_EVERY = 250;
	localparam int TAIL_CYCLES = 20;       // margin after the last result

	// shadow of the walker's own state
	typedef struct packed {
		logic            busy;
		logic [1:0]      level;
		logic [VA_W-1:0] vaddr;
	} walk_t;

	// one scripted transaction; drain_first holds it back until nothing is owed
	typedef struct {
		item_t txn;
		bit    drain_first;
	} stim_t;

	typedef enum int {
		PTE_INVALID,
		PTE_LEAF,
		PTE_TABLE
	} pte_kind_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;   // virt_addr, root_word, read_data
	logic                 s_tuser  = OP_REQ;   // op
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;         // read_addr, xlat_addr, fault
	logic                 m_tuser;         // kind

	sv39_page_table_walker_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	stim_t   walk_items[$];      // transactions still to be offered
	result_t due_results[$];     // predicted output transactions, oldest first

	walk_t   plan_walk   = '0;   // walker state as the script sees it
	walk_t   shadow_walk = '0;   // walker state at the accept point
	walk_t   walk_next;
	item_t   on_offer    = '0;
	result_t predicted;
	result_t got_res;
	result_t want_res;
	stim_t   head_stim;
	logic    offer_now;
	logic    take_now;
	logic    calm        = 1'b0;

	int src_gap     = 0;
	int sink_gap    = 0;
	int sink_hold   = 0;
	int live_n      = 0;
	int accepted_n  = 0;
	int dropped_n   = 0;
	int read_n      = 0;
	int fault_n     = 0;
	int seen_n      = 0;
	int mismatch_n  = 0;
	int cycle_n     = 0;
	int leaf_n[3]   = '{0, 0, 0};

	// Next state and output of the walker for one accepted transaction.
	// Returns 0 when the transaction is swallowed without a result.
	function automatic bit walk_step(input walk_t cur, input item_t txn,
			output walk_t nxt, output result_t res);
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] off;
		logic [1:0]        lvl;
		nxt = cur;
		res = '0;
		if (txn.op == OP_REQ) begin
			if (cur.busy)
				return 1'b0;
			res.kind = KIND_DONE;
			// top-level index other than zero: fault straight away, stay idle
			if (txn.virt_addr[VA_W-1:OFF_L2_W] != '0) begin
				res.fault = 1'b1;
				return 1'b1;
			end
			nxt.busy  = 1'b1;
			nxt.level = 2'd2;
			nxt.vaddr = txn.virt_addr;
			res.kind  = KIND_READ;
			res.read_addr = ADDR_W'(txn.root_word[PPN_W-1:0]) << PAGE_SHIFT;
			return 1'b1;
		end
		if (!cur.busy)
			return 1'b0;
		res.kind = KIND_DONE;
		if (!txn.read_data[PTE_V]) begin
			nxt.busy  = 1'b0;
			nxt.level = 2'd0;
			res.fault = 1'b1;
			return 1'b1;
		end
		base = ADDR_W'(txn.read_data[PPN_SHIFT +: PPN_W]) << PAGE_SHIFT;
		if (cur.level != 2'd0 && txn.read_data[PTE_X:PTE_R] == '0) begin
			// pointer to the next table down
			lvl = cur.level - 2'd1;
			nxt.level = lvl;
			res.kind  = KIND_READ;
			res.read_addr = base +
				(ADDR_W'(cur.vaddr[PAGE_SHIFT + IDX_W * lvl +: IDX_W]) << 3);
			return 1'b1;
		end
		// leaf: superpage bits of the page number are ORed in, not checked
		case (cur.level)
			2'd2: off = ADDR_W'(cur.vaddr[OFF_L2_W-1:0]);
			2'd1: off = ADDR_W'(cur.vaddr[OFF_L1_W-1:0]);
			default: off = ADDR_W'(cur.vaddr[OFF_L0_W-1:0]);
		endcase
		nxt.busy  = 1'b0;
		nxt.level = 2'd0;
		res.xlat_addr = base | off;
		return 1'b1;
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [VA_W-1:0] rand_va();
		return VA_W'({$urandom, $urandom});
	endfunction

	// random entry word of the chosen sort; all other bits random
	function automatic logic [WORD_W-1:0] make_pte(input pte_kind_t sort);
		logic [WORD_W-1:0] w;
		w = rand_word();
		case (sort)
			PTE_INVALID: w[PTE_V] = 1'b0;
			PTE_LEAF: begin
				w[PTE_V] = 1'b1;
				if (w[PTE_X:PTE_R] == '0)
					w[PTE_R + $urandom_range(2)] = 1'b1;
			end
			default: begin
				w[PTE_V] = 1'b1;
				w[PTE_X:PTE_R] = '0;
			end
		endcase
		return w;
	endfunction

	// append one transaction to the script and track where the walk stands
	task automatic queue_item(input logic op, input logic [VA_W-1:0] va,
			input logic [WORD_W-1:0] root, input logic [WORD_W-1:0] pte,
			input bit drain);
		stim_t   s;
		walk_t   nxt;
		result_t r;
		s.txn.op        = op;
		s.txn.virt_addr = va;
		s.txn.root_word = root;
		s.txn.read_data = pte;
		s.drain_first   = drain;
		if (walk_step(plan_walk, s.txn, nxt, r))
			live_n++;
		plan_walk = nxt;
		walk_items.push_back(s);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_n++;
		end
	endtask

	initial begin
		forever #6 clk = ~clk;
	end

	// hard stop in case the walker hangs
	initial begin
		while (cycle_n < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_n++;
		end
		$display("timeout after %0d cycles", cycle_n);
		$display("status: fail");
		$finish;
	end

	// Driver: predicts each transaction as it is accepted, then decides
	// whether to offer the next one or sit out an idle burst.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid    <= 1'b0;
			s_tdata     <= '0;
			s_tuser     <= OP_REQ;
			calm        <= 1'b0;
			src_gap     = 0;
			shadow_walk = '0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (walk_step(shadow_walk, on_offer, walk_next, predicted)) begin
					due_results.push_back(predicted);
					if (predicted.kind == KIND_READ)
						read_n++;
					else if (predicted.fault)
						fault_n++;
					else
						leaf_n[shadow_walk.level]++;
				end else begin
					dropped_n++;
				end
				shadow_walk = walk_next;
				accepted_n++;
			end
			// a transaction on offer stays put until taken
			if (!s_tvalid || s_tready) begin
				offer_now = 1'b0;
				if (src_gap > 0) begin
					src_gap--;
				end else if (walk_items.size() > 0 &&
						!(walk_items[0].drain_first && due_results.size() > 0)) begin
					// idle bursts, skipped on every fourth stretch and in the tail
					if (walk_items.size() > CALM_TAIL && (accepted_n / 128) % 4 != 3 &&
							$urandom_range(99) < 20) begin
						src_gap = $urandom_range(8);
					end else begin
						head_stim = walk_items.pop_front();
						on_offer  = head_stim.txn;
						offer_now = 1'b1;
					end
				end
				s_tvalid <= offer_now;
				if (offer_now) begin
					s_tdata <= S_TDATA_W'({on_offer.read_data, on_offer.root_word,
						on_offer.virt_addr});
					s_tuser <= on_offer.op;
				end
			end
			calm <= walk_items.size() <= CALM_TAIL;
		end
	end

	// Monitor: checks each output transaction against the oldest prediction
	// and drives m_tready, including two long hold-offs that back the walker up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			sink_gap  = 0;
			sink_hold = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.kind      = m_tuser;
				got_res.read_addr = m_tdata[ADDR_W-1:0];
				got_res.xlat_addr = m_tdata[2*ADDR_W-1:ADDR_W];
				got_res.fault     = m_tdata[2*ADDR_W];
				seen_n++;
				if (due_results.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, actual %p",
						$time, got_res);
					mismatch_n++;
				end else begin
					want_res = due_results.pop_front();
					check_field("kind", 64'(want_res.kind), 64'(got_res.kind));
					check_field("read_addr", 64'(want_res.read_addr), 64'(got_res.read_addr));
					check_field("xlat_addr", 64'(want_res.xlat_addr), 64'(got_res.xlat_addr));
					check_field("fault", 64'(want_res.fault), 64'(got_res.fault));
				end
				if (seen_n == 200 || seen_n == 650)
					sink_hold = 160;
			end
			if (sink_hold > 0) begin
				sink_hold--;
				take_now = 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				take_now = 1'b0;
			end else if (!calm && (seen_n / 128) % 4 != 1 && $urandom_range(99) < 20) begin
				sink_gap = $urandom_range(8);
				take_now = 1'b0;
			end else begin
				take_now = 1'b1;
			end
			m_tready <= take_now;
		end
	end

	initial begin
		logic [VA_W-1:0] va;
		int              pick;
		int              base_live;
		int              next_drain;
		bit              drain;
		pte_kind_t       sort;

		// --- directed part ---
		// top index all ones, then only its lowest bit: both fault at once
		queue_item(OP_REQ, '1, '1, '1, 1'b0);
		queue_item(OP_REQ, VA_W'(1) << OFF_L2_W, '0, '0, 1'b0);
		// entry word with no walk in progress is dropped
		queue_item(OP_RESP, '0, '0, '1, 1'b0);
		// all-ones root word: only the low page-number bits reach the address
		queue_item(OP_REQ, 39'h00_3FFF_FFFF, '1, '0, 1'b0);
		// new request mid-walk is dropped
		queue_item(OP_REQ, '0, '0, '0, 1'b0);
		// full walk, page number all ones, then a bare valid entry at the bottom
		queue_item(OP_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FC01, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FC01, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0001, 1'b0);
		// 1 GB leaf with a misaligned page number
		queue_item(OP_REQ, 39'h00_3AAA_AAAA, 64'h0000_0000_0000_0000, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0ABC_DEF1_2403, 1'b0);
		// 2 MB leaf, execute only
		queue_item(OP_REQ, 39'h00_1234_5678, 64'hFFFF_F000_0000_0123, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_1234_5C01, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_8765_4009, 1'b0);
		// invalid top-level entry
		queue_item(OP_REQ, 39'h00_0000_0FFF, 64'h0000_0FFF_FFFF_FFFF, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		// invalid middle entry
		queue_item(OP_REQ, 39'h00_2000_1000, 64'h8000_0000_0000_0001, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0401, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0000, 1'b0);
		// bottom level: invalid, then every flag and high bit set
		queue_item(OP_REQ, 39'h00_1FFF_F000, 64'h0000_0000_0000_0FFF, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0801, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0C01, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
		queue_item(OP_REQ, 39'h00_0030_0ABC, 64'h0000_0000_0000_0000, '0, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0001, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'h0000_0000_0000_0001, 1'b0);
		queue_item(OP_RESP, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);

		// --- random part: mostly complete walks with random content ---
		base_live  = live_n;
		next_drain = live_n;
		while (live_n - base_live < LIVE_TARGET) begin
			drain = live_n >= next_drain;
			if (drain)
				next_drain = live_n + DRAIN_EVERY;
			pick = $urandom_range(99);
			if (pick < 78) begin
				va = rand_va();
				va[VA_W-1:OFF_L2_W] = '0;
				queue_item(OP_REQ, va, rand_word(), rand_word(), drain);
				while (plan_walk.busy) begin
					if ($urandom_range(99) < 5) begin
						queue_item(OP_REQ, rand_va(), rand_word(), rand_word(), 1'b0);
					end else begin
						pick = $urandom_range(99);
						sort = pick < 15 ? PTE_INVALID : (pick < 50 ? PTE_LEAF : PTE_TABLE);
						queue_item(OP_RESP, rand_va(), rand_word(), make_pte(sort), 1'b0);
					end
				end
			end else if (pick < 88) begin
				va = rand_va();
				if (va[VA_W-1:OFF_L2_W] == '0)
					va[OFF_L2_W + $urandom_range(IDX_W - 1)] = 1'b1;
				queue_item(OP_REQ, va, rand_word(), rand_word(), drain);
			end else if (pick < 94) begin
				queue_item(OP_RESP, rand_va(), rand_word(), rand_word(), drain);
			end else begin
				queue_item(logic'($urandom_range(1)), rand_va(), rand_word(), rand_word(),
					drain);
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (walk_items.size() > 0 || s_tvalid)
			@(posedge clk);
		while (due_results.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d transactions in (%0d dropped): %0d entry reads, %0d faults",
			accepted_n, dropped_n, read_n, fault_n);
		$display("leaves 1G/2M/4K: %0d/%0d/%0d, %0d results checked, %0d mismatches",
			leaf_n[2], leaf_n[1], leaf_n[0], seen_n, mismatch_n);
		if (mismatch_n == 0 && due_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
